/* hw/rtl/color_sample_classifier_top_macros.svh */
// Assertion macros for the color sample classifier RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef COLOR_SAMPLE_CLASSIFIER_TOP_MACROS_SVH
`define COLOR_SAMPLE_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off while rst is high
`define CSC_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("csc: assertion failed");
// next-cycle implication, off while rst is high
`define CSC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("csc: assertion failed");
`else
`define CSC_ASSERT(lbl, pre, post)
`define CSC_ASSERT_NXT(lbl, pre, post)
`endif
`endif

/* hw/rtl/csc_pkg.sv */
// Shared types, constants and the microcode ROM of the color sample classifier.
// No dependencies; used by every module of the block.
package csc_pkg;

  localparam int CAPTURES_DEFAULT = 3;
  localparam int PULSE_W = 16;
  localparam int CAL_W = 8;
  localparam int LEVEL_W = 8;
  localparam int WHITE_W = 10;
  localparam int YELLOW_W = 9;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 10;
  localparam int DVD_W = 16;
  localparam int QUO_W = 8;
  localparam int STEP_W = 5;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED_LOW = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOW = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_HIGH = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_LIMIT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_LIMIT = 4'd7;

  localparam logic [CAL_W-1:0] RED_LOW_RST = 8'd25;
  localparam logic [CAL_W-1:0] RED_HIGH_RST = 8'd54;
  localparam logic [CAL_W-1:0] GREEN_LOW_RST = 8'd15;
  localparam logic [CAL_W-1:0] GREEN_HIGH_RST = 8'd100;
  localparam logic [CAL_W-1:0] BLUE_LOW_RST = 8'd10;
  localparam logic [CAL_W-1:0] BLUE_HIGH_RST = 8'd90;
  localparam logic [WHITE_W-1:0] WHITE_LIMIT_RST = 10'd600;
  localparam logic [YELLOW_W-1:0] YELLOW_LIMIT_RST = 9'd270;

  localparam logic [1:0] CLASS_UNDEFINED = 2'd0;
  localparam logic [1:0] CLASS_WHITE = 2'd1;
  localparam logic [1:0] CLASS_YELLOW = 2'd2;
  localparam logic [1:0] CLASS_BLUE = 2'd3;

  typedef struct packed {
    logic [PULSE_W-1:0] red_pulse;
    logic [PULSE_W-1:0] green_pulse;
    logic [PULSE_W-1:0] blue_pulse;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [1:0]         color_class;
  } out_t;

  typedef enum logic [3:0] {
    OP_WAIT_IN,
    OP_MAP_SETUP,
    OP_DIV,
    OP_ACCUM,
    OP_COUNT,
    OP_MEAN_SETUP,
    OP_MEAN_STORE,
    OP_EMIT,
    OP_JUMP
  } op_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef struct packed {
    op_t               op;
    chan_t             chan;
    logic [STEP_W-1:0] target;
  } uword_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic special;
    logic div_last;
    logic count_final;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    logic load;
    logic iterate;
  } div_ctl_t;

  // program addresses
  localparam logic [STEP_W-1:0] S_FETCH = 5'd0;
  localparam logic [STEP_W-1:0] S_MAP_R = 5'd1;
  localparam logic [STEP_W-1:0] S_DIV_R = 5'd2;
  localparam logic [STEP_W-1:0] S_ACC_R = 5'd3;
  localparam logic [STEP_W-1:0] S_MAP_G = 5'd4;
  localparam logic [STEP_W-1:0] S_DIV_G = 5'd5;
  localparam logic [STEP_W-1:0] S_ACC_G = 5'd6;
  localparam logic [STEP_W-1:0] S_MAP_B = 5'd7;
  localparam logic [STEP_W-1:0] S_DIV_B = 5'd8;
  localparam logic [STEP_W-1:0] S_ACC_B = 5'd9;
  localparam logic [STEP_W-1:0] S_COUNT = 5'd10;
  localparam logic [STEP_W-1:0] S_MSET_R = 5'd11;
  localparam logic [STEP_W-1:0] S_MDIV_R = 5'd12;
  localparam logic [STEP_W-1:0] S_MST_R = 5'd13;
  localparam logic [STEP_W-1:0] S_MSET_G = 5'd14;
  localparam logic [STEP_W-1:0] S_MDIV_G = 5'd15;
  localparam logic [STEP_W-1:0] S_MST_G = 5'd16;
  localparam logic [STEP_W-1:0] S_MSET_B = 5'd17;
  localparam logic [STEP_W-1:0] S_MDIV_B = 5'd18;
  localparam logic [STEP_W-1:0] S_MST_B = 5'd19;
  localparam logic [STEP_W-1:0] S_EMIT = 5'd20;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_JUMP, chan: CH_RED, target: S_FETCH};
    case (step)
      S_FETCH:  w = '{op: OP_WAIT_IN,    chan: CH_RED,   target: S_FETCH};
      S_MAP_R:  w = '{op: OP_MAP_SETUP,  chan: CH_RED,   target: S_ACC_R};
      S_DIV_R:  w = '{op: OP_DIV,        chan: CH_RED,   target: S_FETCH};
      S_ACC_R:  w = '{op: OP_ACCUM,      chan: CH_RED,   target: S_FETCH};
      S_MAP_G:  w = '{op: OP_MAP_SETUP,  chan: CH_GREEN, target: S_ACC_G};
      S_DIV_G:  w = '{op: OP_DIV,        chan: CH_GREEN, target: S_FETCH};
      S_ACC_G:  w = '{op: OP_ACCUM,      chan: CH_GREEN, target: S_FETCH};
      S_MAP_B:  w = '{op: OP_MAP_SETUP,  chan: CH_BLUE,  target: S_ACC_B};
      S_DIV_B:  w = '{op: OP_DIV,        chan: CH_BLUE,  target: S_FETCH};
      S_ACC_B:  w = '{op: OP_ACCUM,      chan: CH_BLUE,  target: S_FETCH};
      S_COUNT:  w = '{op: OP_COUNT,      chan: CH_RED,   target: S_FETCH};
      S_MSET_R: w = '{op: OP_MEAN_SETUP, chan: CH_RED,   target: S_FETCH};
      S_MDIV_R: w = '{op: OP_DIV,        chan: CH_RED,   target: S_FETCH};
      S_MST_R:  w = '{op: OP_MEAN_STORE, chan: CH_RED,   target: S_FETCH};
      S_MSET_G: w = '{op: OP_MEAN_SETUP, chan: CH_GREEN, target: S_FETCH};
      S_MDIV_G: w = '{op: OP_DIV,        chan: CH_GREEN, target: S_FETCH};
      S_MST_G:  w = '{op: OP_MEAN_STORE, chan: CH_GREEN, target: S_FETCH};
      S_MSET_B: w = '{op: OP_MEAN_SETUP, chan: CH_BLUE,  target: S_FETCH};
      S_MDIV_B: w = '{op: OP_DIV,        chan: CH_BLUE,  target: S_FETCH};
      S_MST_B:  w = '{op: OP_MEAN_STORE, chan: CH_BLUE,  target: S_FETCH};
      S_EMIT:   w = '{op: OP_EMIT,       chan: CH_RED,   target: S_FETCH};
      default:  w = '{op: OP_JUMP,       chan: CH_RED,   target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/csc_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on csc_pkg. Requires dividend < divisor * 2**QUO_W.
module csc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  csc_pkg::div_ctl_t             ctl,
  input  logic [csc_pkg::DVD_W-1:0]     dividend,
  input  logic [csc_pkg::QUO_W-1:0]     divisor,
  output logic [csc_pkg::QUO_W-1:0]     quotient,
  output logic                          last
);

  localparam int REM_W = csc_pkg::DVD_W - csc_pkg::QUO_W;
  localparam int IT_W = $clog2(csc_pkg::QUO_W);

  logic [REM_W-1:0]          rem;
  logic [csc_pkg::QUO_W-1:0] lo;
  logic [csc_pkg::QUO_W-1:0] dvsr;
  logic [IT_W-1:0]           iter;
  logic [REM_W:0]            trial;
  logic                      ge;

  assign trial = {rem, lo[csc_pkg::QUO_W-1]};
  assign ge = trial >= (REM_W+1)'(dvsr);
  assign last = iter == IT_W'(csc_pkg::QUO_W - 1);
  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (ctl.load) begin
      iter <= '0;
    end else if (ctl.iterate) begin
      iter <= iter + 1'b1;
    end
  end

  // low half of the dividend shifts out as the quotient shifts in
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem  <= dividend[csc_pkg::DVD_W-1:csc_pkg::QUO_W];
      lo   <= dividend[csc_pkg::QUO_W-1:0];
      dvsr <= divisor;
    end else if (ctl.iterate) begin
      rem <= ge ? REM_W'(trial - (REM_W+1)'(dvsr)) : trial[REM_W-1:0];
      lo  <= {lo[csc_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

/* hw/rtl/csc_sequencer.sv */
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on csc_pkg (control word types and program ROM).
module csc_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  csc_pkg::seq_status_t  status,
  output csc_pkg::uword_t       ctl
);

  logic [csc_pkg::STEP_W-1:0] step;
  logic [csc_pkg::STEP_W-1:0] step_next;
  logic [csc_pkg::STEP_W-1:0] step_inc;

  assign ctl = csc_pkg::ucode_rom(step);
  assign step_inc = step + 1'b1;

  always_comb begin
    case (ctl.op)
      csc_pkg::OP_WAIT_IN:   step_next = status.in_fire ? step_inc : step;
      csc_pkg::OP_MAP_SETUP: step_next = status.special ? ctl.target : step_inc;
      csc_pkg::OP_DIV:       step_next = status.div_last ? step_inc : step;
      csc_pkg::OP_COUNT:     step_next = status.count_final ? step_inc : ctl.target;
      csc_pkg::OP_EMIT:      step_next = status.out_free ? ctl.target : step;
      csc_pkg::OP_JUMP:      step_next = ctl.target;
      default:               step_next = step_inc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= csc_pkg::S_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* hw/rtl/color_sample_classifier_top.sv */
// Color sample classifier: the top level with its datapath.
// Depends on csc_pkg, csc_sequencer, csc_divider and the assertion macro header.
//
// Usage:
//   in_valid/in_ready/in_data carry one capture of red, green and blue pulse
//   widths. Each is mapped to a 0..255 level from the calibration registers
//   and summed per channel. After every CAPTURES_PER_DECISION captures the
//   sums are divided down to means and classified, and one result leaves on
//   out_valid/out_ready/out_data; other captures give no result.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the calibration and limit
//   registers; cfg_ready is always high, indexes past the list are dropped.
// Timing: one item at a time, driven by a microcode program. A capture runs
//   through fetch, three channel mappings on the shared divider and a count
//   step; a channel at or outside its limits skips the divider. The capture
//   that closes a group also runs the three mean divisions and the output
//   load. in_ready is high only in fetch.
// Reset: sums and count clear, registers take their defaults, the program
//   restarts at the fetch step and any pending result is dropped.
// Stall: the result waits in the output register; the next capture is still
//   taken, and the following result waits until that register is free.
`include "color_sample_classifier_top_macros.svh"

module color_sample_classifier_top #(
  parameter int CAPTURES_PER_DECISION = csc_pkg::CAPTURES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  csc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output csc_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [csc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TOTAL_W = $clog2(255 * CAPTURES_PER_DECISION + 1);
  localparam int CNT_W = (CAPTURES_PER_DECISION > 1) ? $clog2(CAPTURES_PER_DECISION) : 1;
  localparam int CAL_W = csc_pkg::CAL_W;
  localparam int LVL_W = csc_pkg::LEVEL_W;

  csc_pkg::uword_t      ctl;
  csc_pkg::seq_status_t status;
  csc_pkg::div_ctl_t    div_ctl;

  // configuration registers
  logic [CAL_W-1:0]            red_low, red_high, green_low, green_high;
  logic [CAL_W-1:0]            blue_low, blue_high;
  logic [csc_pkg::WHITE_W-1:0] white_limit;
  logic [csc_pkg::YELLOW_W-1:0] yellow_limit;

  csc_pkg::in_t                capture;
  logic [TOTAL_W-1:0]          red_total, green_total, blue_total;
  logic [CNT_W-1:0]            capture_count;
  logic [LVL_W-1:0]            red_mean, green_mean, blue_mean;

  logic [csc_pkg::PULSE_W-1:0] pulse;
  logic [CAL_W-1:0]            cal_low, cal_high;
  logic [TOTAL_W-1:0]          total_sel;
  logic                        at_or_below_low;
  logic                        level_zero;
  logic [CAL_W-1:0]            diff;
  logic [csc_pkg::DVD_W-1:0]   scaled;
  logic [csc_pkg::DVD_W-1:0]   dividend;
  logic [csc_pkg::QUO_W-1:0]   divisor;
  logic [csc_pkg::QUO_W-1:0]   quotient;
  logic [LVL_W-1:0]            level;
  logic                        div_last;
  logic                        in_fire;
  logic                        out_free;
  logic                        count_final;
  logic [LVL_W:0]              rg_sum;
  logic [csc_pkg::WHITE_W-1:0] rgb_sum;
  logic [1:0]                  color;
  logic [TOTAL_W-1:0]          total_bound;
  logic                        group_empty;
  logic                        totals_bounded;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_low      <= csc_pkg::RED_LOW_RST;
      red_high     <= csc_pkg::RED_HIGH_RST;
      green_low    <= csc_pkg::GREEN_LOW_RST;
      green_high   <= csc_pkg::GREEN_HIGH_RST;
      blue_low     <= csc_pkg::BLUE_LOW_RST;
      blue_high    <= csc_pkg::BLUE_HIGH_RST;
      white_limit  <= csc_pkg::WHITE_LIMIT_RST;
      yellow_limit <= csc_pkg::YELLOW_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csc_pkg::REG_RED_LOW:      red_low      <= cfg_data[CAL_W-1:0];
        csc_pkg::REG_RED_HIGH:     red_high     <= cfg_data[CAL_W-1:0];
        csc_pkg::REG_GREEN_LOW:    green_low    <= cfg_data[CAL_W-1:0];
        csc_pkg::REG_GREEN_HIGH:   green_high   <= cfg_data[CAL_W-1:0];
        csc_pkg::REG_BLUE_LOW:     blue_low     <= cfg_data[CAL_W-1:0];
        csc_pkg::REG_BLUE_HIGH:    blue_high    <= cfg_data[CAL_W-1:0];
        csc_pkg::REG_WHITE_LIMIT:  white_limit  <= cfg_data[csc_pkg::WHITE_W-1:0];
        csc_pkg::REG_YELLOW_LIMIT: yellow_limit <= cfg_data[csc_pkg::YELLOW_W-1:0];
        default: ;
      endcase
    end
  end

  csc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  csc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .last     (div_last)
  );

  assign in_ready = ctl.op == csc_pkg::OP_WAIT_IN;
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign count_final = capture_count == CNT_W'(CAPTURES_PER_DECISION - 1);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      capture <= in_data;
    end
  end

  always_comb begin
    case (ctl.chan)
      csc_pkg::CH_GREEN: begin
        pulse = capture.green_pulse;
        cal_low = green_low;
        cal_high = green_high;
        total_sel = green_total;
      end
      csc_pkg::CH_BLUE: begin
        pulse = capture.blue_pulse;
        cal_low = blue_low;
        cal_high = blue_high;
        total_sel = blue_total;
      end
      default: begin
        pulse = capture.red_pulse;
        cal_low = red_low;
        cal_high = red_high;
        total_sel = red_total;
      end
    endcase
  end

  // outside the special cases pulse < high <= 255, so the low byte is exact
  assign at_or_below_low = pulse <= csc_pkg::PULSE_W'(cal_low);
  assign level_zero = (cal_high <= cal_low) || (pulse >= csc_pkg::PULSE_W'(cal_high));
  assign diff = pulse[CAL_W-1:0] - cal_low;
  assign scaled = {diff, 8'h00} - csc_pkg::DVD_W'(diff);

  // a special case preloads the quotient so that level = ~quotient
  always_comb begin
    div_ctl.load = 1'b0;
    div_ctl.iterate = ctl.op == csc_pkg::OP_DIV;
    dividend = scaled;
    divisor = cal_high - cal_low;
    case (ctl.op)
      csc_pkg::OP_MAP_SETUP: begin
        div_ctl.load = 1'b1;
        if (at_or_below_low) begin
          dividend = '0;
        end else if (level_zero) begin
          dividend = csc_pkg::DVD_W'(csc_pkg::LEVEL_MAX);
        end
      end
      csc_pkg::OP_MEAN_SETUP: begin
        div_ctl.load = 1'b1;
        dividend = csc_pkg::DVD_W'(total_sel);
        divisor = csc_pkg::QUO_W'(CAPTURES_PER_DECISION);
      end
      default: ;
    endcase
  end

  assign status.in_fire = in_fire;
  assign status.special = at_or_below_low || level_zero;
  assign status.div_last = div_last;
  assign status.count_final = count_final;
  assign status.out_free = out_free;

  assign level = ~quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_total <= '0;
      green_total <= '0;
      blue_total <= '0;
      capture_count <= '0;
    end else begin
      case (ctl.op)
        csc_pkg::OP_ACCUM: begin
          case (ctl.chan)
            csc_pkg::CH_GREEN: green_total <= green_total + TOTAL_W'(level);
            csc_pkg::CH_BLUE:  blue_total  <= blue_total + TOTAL_W'(level);
            default:           red_total   <= red_total + TOTAL_W'(level);
          endcase
        end
        csc_pkg::OP_COUNT: begin
          capture_count <= count_final ? '0 : capture_count + 1'b1;
        end
        csc_pkg::OP_MEAN_STORE: begin
          case (ctl.chan)
            csc_pkg::CH_GREEN: green_total <= '0;
            csc_pkg::CH_BLUE:  blue_total  <= '0;
            default:           red_total   <= '0;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == csc_pkg::OP_MEAN_STORE) begin
      case (ctl.chan)
        csc_pkg::CH_GREEN: green_mean <= quotient;
        csc_pkg::CH_BLUE:  blue_mean  <= quotient;
        default:           red_mean   <= quotient;
      endcase
    end
  end

  assign rg_sum = {1'b0, red_mean} + {1'b0, green_mean};
  assign rgb_sum = {1'b0, rg_sum} + csc_pkg::WHITE_W'(blue_mean);

  always_comb begin
    if (rgb_sum > white_limit) begin
      color = csc_pkg::CLASS_WHITE;
    end else if (rg_sum > yellow_limit) begin
      color = csc_pkg::CLASS_YELLOW;
    end else if ({1'b0, rg_sum[LVL_W:2]} < blue_mean) begin
      color = csc_pkg::CLASS_BLUE;
    end else begin
      color = csc_pkg::CLASS_UNDEFINED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == csc_pkg::OP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == csc_pkg::OP_EMIT && out_free) begin
      out_data.red_level <= red_mean;
      out_data.green_level <= green_mean;
      out_data.blue_level <= blue_mean;
      out_data.color_class <= color;
    end
  end

  // per-channel sum can hold at most one full level per capture so far
  assign total_bound = TOTAL_W'(capture_count) * TOTAL_W'(csc_pkg::LEVEL_MAX);
  assign group_empty = (red_total == '0) && (green_total == '0) && (blue_total == '0)
                       && (capture_count == '0);
  assign totals_bounded = (red_total <= total_bound) && (green_total <= total_bound)
                          && (blue_total <= total_bound);

  `CSC_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready)
  `CSC_ASSERT(a_group_cleared_at_emit, ctl.op == csc_pkg::OP_EMIT, group_empty)
  `CSC_ASSERT(a_total_bound, ctl.op == csc_pkg::OP_WAIT_IN, totals_bounded)

endmodule

/* tb/sv/tb_color_sample_classifier_top.sv */
// Self-checking testbench for color_sample_classifier_top: random and directed
// pulse captures and register writes, checked against a scoreboard model.
// Depends on csc_pkg and the RTL of the block only.
module tb_color_sample_classifier_top;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam logic [csc_pkg::CFG_IDX_W-1:0] REG_PAST_LAST = csc_pkg::REG_YELLOW_LIMIT + 1'b1;
  localparam logic [csc_pkg::CFG_IDX_W-1:0] REG_TOP_INDEX = '1;

  // Running model of the mapping, the group averaging and the classifier.
  class level_scoreboard;
    logic [csc_pkg::CAL_W-1:0] pulse_low[3];
    logic [csc_pkg::CAL_W-1:0] pulse_high[3];
    logic [csc_pkg::WHITE_W-1:0] white_limit;
    logic [csc_pkg::YELLOW_W-1:0] yellow_limit;
    int unsigned level_sum[3];
    int unsigned captures;
    csc_pkg::out_t pending[$];
    int errors;

    function new();
      pulse_low[csc_pkg::CH_RED] = csc_pkg::RED_LOW_RST;
      pulse_high[csc_pkg::CH_RED] = csc_pkg::RED_HIGH_RST;
      pulse_low[csc_pkg::CH_GREEN] = csc_pkg::GREEN_LOW_RST;
      pulse_high[csc_pkg::CH_GREEN] = csc_pkg::GREEN_HIGH_RST;
      pulse_low[csc_pkg::CH_BLUE] = csc_pkg::BLUE_LOW_RST;
      pulse_high[csc_pkg::CH_BLUE] = csc_pkg::BLUE_HIGH_RST;
      white_limit = csc_pkg::WHITE_LIMIT_RST;
      yellow_limit = csc_pkg::YELLOW_LIMIT_RST;
      level_sum = '{0, 0, 0};
      captures = 0;
      errors = 0;
    endfunction

    // bits above the register width are dropped, unknown indexes ignored
    function void write_reg(logic [csc_pkg::CFG_IDX_W-1:0] idx,
                            logic [csc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        csc_pkg::REG_RED_LOW: pulse_low[csc_pkg::CH_RED] = data[csc_pkg::CAL_W-1:0];
        csc_pkg::REG_RED_HIGH: pulse_high[csc_pkg::CH_RED] = data[csc_pkg::CAL_W-1:0];
        csc_pkg::REG_GREEN_LOW: pulse_low[csc_pkg::CH_GREEN] = data[csc_pkg::CAL_W-1:0];
        csc_pkg::REG_GREEN_HIGH: pulse_high[csc_pkg::CH_GREEN] = data[csc_pkg::CAL_W-1:0];
        csc_pkg::REG_BLUE_LOW: pulse_low[csc_pkg::CH_BLUE] = data[csc_pkg::CAL_W-1:0];
        csc_pkg::REG_BLUE_HIGH: pulse_high[csc_pkg::CH_BLUE] = data[csc_pkg::CAL_W-1:0];
        csc_pkg::REG_WHITE_LIMIT: white_limit = data[csc_pkg::WHITE_W-1:0];
        csc_pkg::REG_YELLOW_LIMIT: yellow_limit = data[csc_pkg::YELLOW_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [csc_pkg::LEVEL_W-1:0] level_of(logic [csc_pkg::PULSE_W-1:0] p,
                                                   logic [csc_pkg::CAL_W-1:0] lo,
                                                   logic [csc_pkg::CAL_W-1:0] hi);
      int q;
      if (p <= lo) return csc_pkg::LEVEL_MAX;
      // inverted or flat calibration: anything above low reads as dark
      if (hi <= lo) return '0;
      q = (int'(csc_pkg::LEVEL_MAX) * (int'(p) - int'(lo))) / (int'(hi) - int'(lo));
      if (q >= int'(csc_pkg::LEVEL_MAX)) return '0;
      return csc_pkg::LEVEL_W'(int'(csc_pkg::LEVEL_MAX) - q);
    endfunction

    function void note_capture(csc_pkg::in_t c);
      int unsigned r, g, b, rg;
      csc_pkg::out_t res;
      level_sum[csc_pkg::CH_RED] += level_of(c.red_pulse, pulse_low[csc_pkg::CH_RED],
                                             pulse_high[csc_pkg::CH_RED]);
      level_sum[csc_pkg::CH_GREEN] += level_of(c.green_pulse, pulse_low[csc_pkg::CH_GREEN],
                                               pulse_high[csc_pkg::CH_GREEN]);
      level_sum[csc_pkg::CH_BLUE] += level_of(c.blue_pulse, pulse_low[csc_pkg::CH_BLUE],
                                              pulse_high[csc_pkg::CH_BLUE]);
      captures++;
      if (captures < csc_pkg::CAPTURES_DEFAULT) return;
      r = level_sum[csc_pkg::CH_RED] / csc_pkg::CAPTURES_DEFAULT;
      g = level_sum[csc_pkg::CH_GREEN] / csc_pkg::CAPTURES_DEFAULT;
      b = level_sum[csc_pkg::CH_BLUE] / csc_pkg::CAPTURES_DEFAULT;
      level_sum = '{0, 0, 0};
      captures = 0;
      rg = r + g;
      res.red_level = csc_pkg::LEVEL_W'(r);
      res.green_level = csc_pkg::LEVEL_W'(g);
      res.blue_level = csc_pkg::LEVEL_W'(b);
      if (rg + b > white_limit) res.color_class = csc_pkg::CLASS_WHITE;
      else if (rg > yellow_limit) res.color_class = csc_pkg::CLASS_YELLOW;
      else if ((rg >> 2) < b) res.color_class = csc_pkg::CLASS_BLUE;
      else res.color_class = csc_pkg::CLASS_UNDEFINED;
      pending.push_back(res);
    endfunction

    function void check_result(csc_pkg::out_t got);
      csc_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("result request with no group pending: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.red_level !== want.red_level) begin
        $error("red_level: expected %0d, got %0d", want.red_level, got.red_level);
        errors++;
      end
      if (got.green_level !== want.green_level) begin
        $error("green_level: expected %0d, got %0d", want.green_level, got.green_level);
        errors++;
      end
      if (got.blue_level !== want.blue_level) begin
        $error("blue_level: expected %0d, got %0d", want.blue_level, got.blue_level);
        errors++;
      end
      if (got.color_class !== want.color_class) begin
        $error("color_class: expected %0d, got %0d", want.color_class, got.color_class);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  csc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  csc_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [csc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [csc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  level_scoreboard sb;
  bit calm = 1'b1;
  bit hold_off_req = 1'b0;
  int quiet_cycles = 0;

  color_sample_classifier_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // note each accepted request, check each result, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_capture(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(99) < 23) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid is left high on return; callers drop it before going idle
  task automatic send_capture(input logic [csc_pkg::PULSE_W-1:0] r,
                              input logic [csc_pkg::PULSE_W-1:0] g,
                              input logic [csc_pkg::PULSE_W-1:0] b);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{red_pulse: r, green_pulse: g, blue_pulse: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_reg(input logic [csc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [csc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [csc_pkg::CFG_DATA_W-1:0] rl,
                               input logic [csc_pkg::CFG_DATA_W-1:0] rh,
                               input logic [csc_pkg::CFG_DATA_W-1:0] gl,
                               input logic [csc_pkg::CFG_DATA_W-1:0] gh,
                               input logic [csc_pkg::CFG_DATA_W-1:0] bl,
                               input logic [csc_pkg::CFG_DATA_W-1:0] bh,
                               input logic [csc_pkg::CFG_DATA_W-1:0] wl,
                               input logic [csc_pkg::CFG_DATA_W-1:0] yl);
    program_reg(csc_pkg::REG_RED_LOW, rl);
    program_reg(csc_pkg::REG_RED_HIGH, rh);
    program_reg(csc_pkg::REG_GREEN_LOW, gl);
    program_reg(csc_pkg::REG_GREEN_HIGH, gh);
    program_reg(csc_pkg::REG_BLUE_LOW, bl);
    program_reg(csc_pkg::REG_BLUE_HIGH, bh);
    program_reg(csc_pkg::REG_WHITE_LIMIT, wl);
    program_reg(csc_pkg::REG_YELLOW_LIMIT, yl);
  endtask

  // drains all results, then lets the last capture finish its mapping
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly around the calibration window, some full-range and edge values
  function automatic logic [csc_pkg::PULSE_W-1:0] pick_pulse(logic [csc_pkg::CAL_W-1:0] lo,
                                                             logic [csc_pkg::CAL_W-1:0] hi);
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 55) return csc_pkg::PULSE_W'($urandom_range(0, 300));
    if (roll < 75) return csc_pkg::PULSE_W'($urandom);
    if (roll < 90) begin
      v = ($urandom_range(1) ? int'(lo) : int'(hi)) + int'($urandom_range(0, 4)) - 2;
      return (v < 0) ? '0 : csc_pkg::PULSE_W'(v);
    end
    return $urandom_range(1) ? '1 : '0;
  endfunction

  task automatic send_random(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      send_capture(pick_pulse(sb.pulse_low[csc_pkg::CH_RED], sb.pulse_high[csc_pkg::CH_RED]),
                   pick_pulse(sb.pulse_low[csc_pkg::CH_GREEN],
                              sb.pulse_high[csc_pkg::CH_GREEN]),
                   pick_pulse(sb.pulse_low[csc_pkg::CH_BLUE], sb.pulse_high[csc_pkg::CH_BLUE]));
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset calibration: white, undefined, blue, yellow, near-low groups
    repeat (3) send_capture('0, '0, '0);
    repeat (3) send_capture('1, '1, '1);
    repeat (3) send_capture(16'd54, 16'd100, 16'd10);
    repeat (3) send_capture(16'd25, 16'd15, 16'hFFFF);
    repeat (3) send_capture(16'd26, 16'd16, 16'd11);
    send_capture(16'd40, 16'd58, 16'd50);
    send_capture(16'd30, 16'd90, 16'd89);
    send_capture(16'd53, 16'd20, 16'd70);
    send_random(200, -1);
    wait_idle();

    // high below low, high equal to low, both zero
    calm = 1'b0;
    load_settings(10'd200, 10'd100, 10'd50, 10'd50, 10'd0, 10'd0, 10'd600, 10'd270);
    send_capture(16'd200, 16'd50, 16'd0);
    send_capture(16'd201, 16'd51, 16'd1);
    send_capture(16'hFFFF, 16'd0, 16'hFFFF);
    send_random(200, 60);
    wait_idle();

    // widest window; over-wide data must be truncated to the register width
    load_settings(10'd0, 10'h3FF, 10'd0, 10'h3FF, 10'd0, 10'h3FF, 10'd765, 10'h3FF);
    program_reg(REG_PAST_LAST, 10'h3FF);
    program_reg(REG_TOP_INDEX, 10'h000);
    send_random(200, -1);
    wait_idle();

    // never white, yellow as soon as red plus green is nonzero
    load_settings(10'd255, 10'd255, 10'd255, 10'd255, 10'd255, 10'd255, 10'h3FF, 10'd0);
    send_random(150, -1);
    wait_idle();

    load_settings(10'd0, 10'd1, 10'd100, 10'd101, 10'd30, 10'd250, 10'd0, 10'd510);
    send_random(100, -1);
    wait_idle();

    load_settings(csc_pkg::CFG_DATA_W'($urandom_range(0, 120)),
                  csc_pkg::CFG_DATA_W'($urandom_range(60, 255)),
                  csc_pkg::CFG_DATA_W'($urandom_range(0, 120)),
                  csc_pkg::CFG_DATA_W'($urandom_range(60, 255)),
                  csc_pkg::CFG_DATA_W'($urandom_range(0, 120)),
                  csc_pkg::CFG_DATA_W'($urandom_range(60, 255)),
                  csc_pkg::CFG_DATA_W'($urandom_range(300, 765)),
                  csc_pkg::CFG_DATA_W'($urandom_range(100, 510)));
    send_random(150, -1);
    wait_idle();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
